// ----- rtl/tse_pkg.sv -----
// Shared definitions for the topological sort engine.
// Holds field widths, command codes and the in-degree lane control struct.
// No dependencies; tse_deg_lanes, the engine and the testbench import this package.
`default_nettype none

package tse_pkg;

    localparam int VERTEX_W = 6;   // width of a vertex field on the ports
    localparam int COUNT_W  = 7;   // width of the vertex count register
    localparam int CMD_W    = 2;

    localparam logic [CMD_W-1:0] CMD_ADD_EDGE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SORT     = 2'd2;

    // Control of the in-degree lanes for one cycle.
    typedef struct packed {
        logic clear;   // zero every lane
        logic inc;     // add the presented row into the lanes
        logic dec;     // subtract the presented row from the lanes
    } deg_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/tse_adj_mem.sv -----
// Adjacency matrix store: one synchronous RAM row per source vertex.
// Row valid flags give the cleared state; edge adds are read-modify-write
// with forwarding. Depends on nothing but its parameter.
`default_nettype none

module tse_adj_mem #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            edge_en,
    input  wire logic [$clog2(MAX_VERTICES)-1:0] edge_row,
    input  wire logic [$clog2(MAX_VERTICES)-1:0] edge_col,
    input  wire logic                            clear_all,
    input  wire logic                            rd_en,
    input  wire logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
    output logic      [MAX_VERTICES-1:0]         rd_row
);

    localparam int AW = $clog2(MAX_VERTICES);

    logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];

    logic [MAX_VERTICES-1:0] row_valid_reg, row_valid_next;
    logic [MAX_VERTICES-1:0] rdata_reg;
    logic                    rvld_reg;
    logic                    stg_vld_reg;
    logic [AW-1:0]           stg_row_reg, stg_col_reg;
    logic                    fwd_vld_reg;
    logic [AW-1:0]           fwd_addr_reg;
    logic [MAX_VERTICES-1:0] fwd_data_reg;

    logic                    ren;
    logic [AW-1:0]           raddr;
    logic [MAX_VERTICES-1:0] base_row, new_row;

    assign ren   = edge_en | rd_en;
    assign raddr = edge_en ? edge_row : rd_addr;

    // A row whose valid flag was clear at read time reads as all zero.
    assign rd_row = rvld_reg ? rdata_reg : '0;

    // The previous edge may have written this row at the edge that read it.
    assign base_row = (fwd_vld_reg && (fwd_addr_reg == stg_row_reg)) ? fwd_data_reg : rd_row;
    assign new_row  = base_row | ({{(MAX_VERTICES-1){1'b0}}, 1'b1} << stg_col_reg);

    always_comb begin
        row_valid_next = row_valid_reg;
        if (clear_all) begin
            row_valid_next = '0;
        end else if (stg_vld_reg) begin
            row_valid_next[stg_row_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ren) begin
            rdata_reg <= mem[raddr];
            rvld_reg  <= row_valid_reg[raddr];
        end
        if (stg_vld_reg) begin
            mem[stg_row_reg] <= new_row;
        end
        stg_row_reg  <= edge_row;
        stg_col_reg  <= edge_col;
        fwd_addr_reg <= stg_row_reg;
        fwd_data_reg <= new_row;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            stg_vld_reg   <= 1'b0;
            fwd_vld_reg   <= 1'b0;
        end else begin
            row_valid_reg <= row_valid_next;
            stg_vld_reg   <= edge_en;
            fwd_vld_reg   <= stg_vld_reg;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tse_queue_ram.sv -----
// Ready queue storage: a simple dual-port synchronous RAM of vertex indexes.
// One write and one registered read per cycle. No dependencies.
`default_nettype none

module tse_queue_ram #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic                            aclk,
    input  wire logic                            wr_en,
    input  wire logic [$clog2(MAX_VERTICES)-1:0] wr_addr,
    input  wire logic [$clog2(MAX_VERTICES)-1:0] wr_data,
    input  wire logic                            rd_en,
    input  wire logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
    output logic      [$clog2(MAX_VERTICES)-1:0] rd_data
);

    localparam int AW = $clog2(MAX_VERTICES);

    logic [AW-1:0] mem [MAX_VERTICES];
    logic [AW-1:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tse_deg_lanes.sv -----
// In-degree counters, one lane per vertex, each updated by its own row bit.
// Reports which lanes are zero and which reach zero on a decrement.
// Depends on tse_pkg for the lane control struct.
`default_nettype none

module tse_deg_lanes #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic                    aclk,
    input  wire tse_pkg::deg_ctl_t       ctl,
    input  wire logic [MAX_VERTICES-1:0] row,
    input  wire logic [MAX_VERTICES-1:0] lane_mask,
    output logic      [MAX_VERTICES-1:0] zero_mask,
    output logic      [MAX_VERTICES-1:0] drop_mask
);

    import tse_pkg::*;

    localparam int CW = $clog2(MAX_VERTICES + 1);

    logic [CW-1:0] deg_reg  [MAX_VERTICES];
    logic [CW-1:0] deg_next [MAX_VERTICES];

    always_comb begin
        for (int k = 0; k < MAX_VERTICES; k++) begin
            deg_next[k]  = deg_reg[k];
            if (ctl.clear) begin
                deg_next[k] = '0;
            end else if (ctl.inc && row[k]) begin
                deg_next[k] = deg_reg[k] + CW'(1);
            end else if (ctl.dec && row[k]) begin
                deg_next[k] = deg_reg[k] - CW'(1);
            end
            zero_mask[k] = lane_mask[k] && (deg_reg[k] == '0);
            drop_mask[k] = row[k] && (deg_reg[k] == CW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < MAX_VERTICES; k++) begin
            deg_reg[k] <= deg_next[k];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/topological_sort_engine.sv -----
// Topological sort engine: Kahn sort over a bit adjacency matrix in RAM.
// Uses tse_pkg, tse_adj_mem, tse_queue_ram and tse_deg_lanes.
//
// Usage. The input channel (s_valid/s_ready) carries one command per
// transaction: add an edge s_src -> s_dest, clear all edges, or run a sort.
// Edges with an endpoint at or above the vertex count are dropped. Edge adds
// and clears are taken one per cycle while the engine is idle and give no
// result. A sort returns one transaction per emitted vertex on the result
// channel (m_valid/m_ready) in topological order; the final one has m_last
// set and m_cycle_left tells whether vertices were left over on a cycle. A
// sort that emits nothing gives a single result with m_valid_vertex low.
// A sort with n vertices in use does n row reads to count in-degrees, then
// for every emitted vertex one queue read, one row read and a scan of the
// lanes that dropped to zero. While a sort runs, s_ready is low. Results
// pass through an output register; when the receiver stalls, the sort holds
// at the next emission until the register frees up. The vertex count
// (cfg_wr_en/cfg_wr_data) is to be written only while the engine is idle;
// the engine itself does not enforce this. Reset empties the matrix at once
// through per-row valid flags and zeroes the vertex count; no clearing pass
// is needed.
`default_nettype none

module topological_sort_engine #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [tse_pkg::COUNT_W-1:0]  cfg_wr_data,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [tse_pkg::CMD_W-1:0]    s_command,
    input  wire logic [tse_pkg::VERTEX_W-1:0] s_src,
    input  wire logic [tse_pkg::VERTEX_W-1:0] s_dest,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [tse_pkg::VERTEX_W-1:0] m_vertex,
    output logic                              m_valid_vertex,
    output logic                              m_last,
    output logic                              m_cycle_left
);

    import tse_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    // Sort sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;  // taking commands
    localparam logic [2:0] ST_COUNT = 3'd1;  // reading rows to count in-degrees
    localparam logic [2:0] ST_SCAN  = 3'd2;  // pushing marked vertices in order
    localparam logic [2:0] ST_POP   = 3'd3;  // reading the queue head
    localparam logic [2:0] ST_POPW  = 3'd4;  // emitting the previous vertex
    localparam logic [2:0] ST_DEC   = 3'd5;  // decrementing successors
    localparam logic [2:0] ST_FINAL = 3'd6;  // giving the last result

    logic [2:0]              state_reg, state_next;
    logic [COUNT_W-1:0]      vc_reg;
    logic [CW-1:0]           i_reg, i_next;
    logic [CW-1:0]           j_reg, j_next;
    logic [CW-1:0]           head_reg, head_next;
    logic [CW-1:0]           tail_reg, tail_next;
    logic [CW-1:0]           emitted_reg, emitted_next;
    logic                    cnt_pend_reg, cnt_pend_next;
    logic                    have_pend_reg, have_pend_next;
    logic [AW-1:0]           pend_reg, pend_next;
    logic [MAX_VERTICES-1:0] pend_mask_reg, pend_mask_next;

    logic                    m_valid_reg, m_valid_next;
    logic [VERTEX_W-1:0]     m_vertex_reg;
    logic                    m_valid_vertex_reg, m_last_reg, m_cycle_left_reg;

    logic [CW-1:0]           n_act;
    logic [MAX_VERTICES-1:0] lane_mask, adj_row, row_use, zero_mask, drop_mask;
    logic                    edge_in_range;
    logic                    edge_en, clear_all;
    logic                    adj_rd_en;
    logic [AW-1:0]           adj_rd_addr;
    logic                    q_wr_en, q_rd_en;
    logic [AW-1:0]           q_wr_addr, q_wr_data, q_rd_addr, q_rd_data;
    deg_ctl_t                deg_ctl;
    logic                    out_free, out_load;
    logic [VERTEX_W-1:0]     out_vertex;
    logic                    out_valid_vertex, out_last, out_cycle_left;

    // Counts above the storage depth act as the full depth.
    assign n_act = (vc_reg > COUNT_W'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : vc_reg[CW-1:0];

    for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_lane_mask
        assign lane_mask[g] = (CW'(g) < n_act);
    end

    assign row_use       = adj_row & lane_mask;
    assign edge_in_range = (COUNT_W'(s_src) < COUNT_W'(n_act))
                        && (COUNT_W'(s_dest) < COUNT_W'(n_act));

    assign s_ready        = (state_reg == ST_IDLE);
    assign out_free       = !m_valid_reg || m_ready;
    assign m_valid        = m_valid_reg;
    assign m_vertex       = m_vertex_reg;
    assign m_valid_vertex = m_valid_vertex_reg;
    assign m_last         = m_last_reg;
    assign m_cycle_left   = m_cycle_left_reg;

    tse_adj_mem #(.MAX_VERTICES(MAX_VERTICES)) u_adj (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .edge_en   (edge_en),
        .edge_row  (s_src[AW-1:0]),
        .edge_col  (s_dest[AW-1:0]),
        .clear_all (clear_all),
        .rd_en     (adj_rd_en),
        .rd_addr   (adj_rd_addr),
        .rd_row    (adj_row)
    );

    tse_queue_ram #(.MAX_VERTICES(MAX_VERTICES)) u_queue (
        .aclk    (aclk),
        .wr_en   (q_wr_en),
        .wr_addr (q_wr_addr),
        .wr_data (q_wr_data),
        .rd_en   (q_rd_en),
        .rd_addr (q_rd_addr),
        .rd_data (q_rd_data)
    );

    tse_deg_lanes #(.MAX_VERTICES(MAX_VERTICES)) u_lanes (
        .aclk      (aclk),
        .ctl       (deg_ctl),
        .row       (row_use),
        .lane_mask (lane_mask),
        .zero_mask (zero_mask),
        .drop_mask (drop_mask)
    );

    always_comb begin
        state_next       = state_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        emitted_next     = emitted_reg;
        cnt_pend_next    = cnt_pend_reg;
        have_pend_next   = have_pend_reg;
        pend_next        = pend_reg;
        pend_mask_next   = pend_mask_reg;
        edge_en          = 1'b0;
        clear_all        = 1'b0;
        adj_rd_en        = 1'b0;
        adj_rd_addr      = i_reg[AW-1:0];
        q_wr_en          = 1'b0;
        q_wr_addr        = tail_reg[AW-1:0];
        q_wr_data        = j_reg[AW-1:0];
        q_rd_en          = 1'b0;
        q_rd_addr        = head_reg[AW-1:0];
        deg_ctl          = '0;
        out_load         = 1'b0;
        out_vertex       = '0;
        out_valid_vertex = 1'b0;
        out_last         = 1'b0;
        out_cycle_left   = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_command)
                        CMD_ADD_EDGE: edge_en = edge_in_range;
                        CMD_CLEAR:    clear_all = 1'b1;
                        CMD_SORT: begin
                            deg_ctl.clear  = 1'b1;
                            i_next         = '0;
                            head_next      = '0;
                            tail_next      = '0;
                            emitted_next   = '0;
                            cnt_pend_next  = 1'b0;
                            have_pend_next = 1'b0;
                            state_next     = ST_COUNT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_COUNT: begin
                // Each row read lands in the next cycle and is added to the lanes.
                deg_ctl.inc = cnt_pend_reg;
                if (i_reg < n_act) begin
                    adj_rd_en     = 1'b1;
                    i_next        = i_reg + CW'(1);
                    cnt_pend_next = 1'b1;
                end else begin
                    cnt_pend_next = 1'b0;
                    if (!cnt_pend_reg) begin
                        pend_mask_next = zero_mask;
                        j_next         = '0;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (j_reg < n_act) begin
                    if (pend_mask_reg[j_reg[AW-1:0]]) begin
                        q_wr_en   = 1'b1;
                        tail_next = tail_reg + CW'(1);
                    end
                    j_next = j_reg + CW'(1);
                end else begin
                    state_next = ST_POP;
                end
            end
            ST_POP: begin
                if (head_reg < tail_reg) begin
                    q_rd_en    = 1'b1;
                    head_next  = head_reg + CW'(1);
                    state_next = ST_POPW;
                end else begin
                    state_next = ST_FINAL;
                end
            end
            ST_POPW: begin
                // The held vertex is known not to be last once another follows.
                if (!have_pend_reg || out_free) begin
                    if (have_pend_reg) begin
                        out_load         = 1'b1;
                        out_vertex       = VERTEX_W'(pend_reg);
                        out_valid_vertex = 1'b1;
                    end
                    pend_next      = q_rd_data;
                    have_pend_next = 1'b1;
                    emitted_next   = emitted_reg + CW'(1);
                    adj_rd_en      = 1'b1;
                    adj_rd_addr    = q_rd_data;
                    state_next     = ST_DEC;
                end
            end
            ST_DEC: begin
                deg_ctl.dec    = 1'b1;
                pend_mask_next = drop_mask;
                j_next         = '0;
                state_next     = ST_SCAN;
            end
            ST_FINAL: begin
                if (out_free) begin
                    out_load         = 1'b1;
                    out_last         = 1'b1;
                    out_vertex       = have_pend_reg ? VERTEX_W'(pend_reg) : '0;
                    out_valid_vertex = have_pend_reg;
                    out_cycle_left   = have_pend_reg ? (emitted_reg < n_act)
                                                     : (n_act != '0);
                    state_next       = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            vc_reg        <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            emitted_reg   <= '0;
            cnt_pend_reg  <= 1'b0;
            have_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            if (cfg_wr_en) begin
                vc_reg <= cfg_wr_data;
            end
            i_reg         <= i_next;
            j_reg         <= j_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            emitted_reg   <= emitted_next;
            cnt_pend_reg  <= cnt_pend_next;
            have_pend_reg <= have_pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg      <= pend_next;
        pend_mask_reg <= pend_mask_next;
        if (out_load) begin
            m_vertex_reg       <= out_vertex;
            m_valid_vertex_reg <= out_valid_vertex;
            m_last_reg         <= out_last;
            m_cycle_left_reg   <= out_cycle_left;
        end
    end

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for topological_sort_engine.
// Depends on tse_pkg for widths and command codes, and on the engine's RTL.
// Drives edge, clear and sort commands and checks each emitted vertex.
`default_nettype none

module testbench;

    import tse_pkg::*;

    // Command 3 has no meaning to the engine and must be dropped silently.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int NUM_VERTICES  = 64;
    localparam int RANDOM_ITEMS  = 480;
    // Settling time after the last result before the vertex count may change,
    // and quiet time at the end of the run.
    localparam int DRAIN_CYCLES  = 16;
    // The slowest run here has a handful of 64-vertex sorts and a few dozen
    // small sorts; this bound is many times its length.
    localparam int CYCLE_LIMIT   = 500000;
    localparam int MAX_PRINTED   = 100;

    // One emitted transaction on the result channel.
    typedef struct packed {
        logic [VERTEX_W-1:0] vertex;
        logic                valid_vertex;
        logic                last;
        logic                cycle_left;
    } vtx_result_t;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_COUNT
    } row_kind_t;

    // One row of the directed table: either a vertex count write or a command.
    // A sort row can carry its single result typed in when it is obvious.
    typedef struct packed {
        row_kind_t           kind;
        logic [COUNT_W-1:0]  count;
        logic [CMD_W-1:0]    command;
        logic [VERTEX_W-1:0] src;
        logic [VERTEX_W-1:0] dest;
        logic                typed;
        vtx_result_t         want;
    } stim_row_t;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [COUNT_W-1:0]  cfg_wr_data = '0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    logic [CMD_W-1:0]    s_command   = '0;
    logic [VERTEX_W-1:0] s_src       = '0;
    logic [VERTEX_W-1:0] s_dest      = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic [VERTEX_W-1:0] m_vertex;
    logic                m_valid_vertex;
    logic                m_last;
    logic                m_cycle_left;

    // Shadow copy of the engine's graph and vertex count register.
    logic [NUM_VERTICES-1:0] edge_rows [NUM_VERTICES];
    logic [COUNT_W-1:0]      model_count = '0;

    // Vertices still owed by the engine, oldest first.
    vtx_result_t expected_order [$];

    // When the sort in flight has its result typed into the table, the
    // monitor queues this instead of running the predictor.
    logic        sort_typed = 1'b0;
    vtx_result_t sort_want  = '0;

    // Turns off idling on both channels for a stretch of the random part.
    logic        quiet      = 1'b0;
    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned cycle_count;

    stim_row_t directed_rows [$];

    topological_sort_engine #(
        .MAX_VERTICES(NUM_VERTICES)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_src         (s_src),
        .s_dest        (s_dest),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_vertex      (m_vertex),
        .m_valid_vertex(m_valid_vertex),
        .m_last        (m_last),
        .m_cycle_left  (m_cycle_left)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // A count above the matrix size behaves as the full matrix.
    function automatic int unsigned live_count();
        return (model_count > COUNT_W'(NUM_VERTICES)) ? NUM_VERTICES : int'(model_count);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < MAX_PRINTED) begin
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        end
        mismatches++;
    endtask

    // Kahn's algorithm on the shadow graph. Vertices of in-degree zero are
    // queued in ascending order, then popped first in, first out; each pop
    // lowers the in-degree of its successors and queues those that reach
    // zero. Only vertices below the live count and edges between them count.
    function automatic void predict_sort_order();
        logic [COUNT_W-1:0]  in_deg [NUM_VERTICES];
        logic [VERTEX_W-1:0] ready_fifo [NUM_VERTICES];
        int unsigned         n;
        int unsigned         head;
        int unsigned         tail;
        int unsigned         u;
        vtx_result_t         run_order [$];
        vtx_result_t         r;

        n    = live_count();
        head = 0;
        tail = 0;
        for (int j = 0; j < n; j++) in_deg[j] = '0;
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                if (edge_rows[i][j]) in_deg[j] = in_deg[j] + 1'b1;
            end
        end
        for (int j = 0; j < n; j++) begin
            if (in_deg[j] == 0 && tail < NUM_VERTICES) begin
                ready_fifo[tail] = VERTEX_W'(j);
                tail++;
            end
        end
        while (head < tail) begin
            u = int'(ready_fifo[head]);
            head++;
            r = '{vertex: VERTEX_W'(u), valid_vertex: 1'b1, last: 1'b0, cycle_left: 1'b0};
            run_order.push_back(r);
            for (int j = 0; j < n; j++) begin
                if (edge_rows[u][j]) begin
                    in_deg[j] = in_deg[j] - 1'b1;
                    if (in_deg[j] == 0 && tail < NUM_VERTICES) begin
                        ready_fifo[tail] = VERTEX_W'(j);
                        tail++;
                    end
                end
            end
        end

        // An empty run still ends with one marker transaction.
        if (run_order.size() == 0) begin
            r = '{vertex: '0, valid_vertex: 1'b0, last: 1'b1, cycle_left: (n > 0)};
            run_order.push_back(r);
        end else begin
            r            = run_order[run_order.size() - 1];
            r.last       = 1'b1;
            r.cycle_left = (run_order.size() < n);
            run_order[run_order.size() - 1] = r;
        end
        foreach (run_order[k]) expected_order.push_back(run_order[k]);
    endfunction

    // Monitor. Everything is sampled at the rising edge, so inputs that
    // were driven at the falling edge are stable here. The shadow state is
    // updated in the order the engine sees the transactions.
    always @(posedge aclk) begin
        vtx_result_t want;
        if (!aresetn) begin
            foreach (edge_rows[i]) edge_rows[i] = '0;
            model_count = '0;
        end else begin
            if (cfg_wr_en) model_count = cfg_wr_data;
            if (s_valid && s_ready) begin
                case (s_command)
                    CMD_ADD_EDGE: begin
                        if (s_src < live_count() && s_dest < live_count()) begin
                            edge_rows[s_src][s_dest] = 1'b1;
                        end
                    end
                    CMD_CLEAR: begin
                        foreach (edge_rows[i]) edge_rows[i] = '0;
                    end
                    CMD_SORT: begin
                        if (sort_typed) expected_order.push_back(sort_want);
                        else predict_sort_order();
                    end
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_order.size() == 0) begin
                    report_mismatch("unexpected result, vertex", int'(m_vertex), 0);
                end else begin
                    want = expected_order.pop_front();
                    if (m_vertex !== want.vertex) begin
                        report_mismatch("vertex", int'(m_vertex), int'(want.vertex));
                    end
                    if (m_valid_vertex !== want.valid_vertex) begin
                        report_mismatch("valid_vertex", int'(m_valid_vertex),
                                        int'(want.valid_vertex));
                    end
                    if (m_last !== want.last) begin
                        report_mismatch("last", int'(m_last), int'(want.last));
                    end
                    if (m_cycle_left !== want.cycle_left) begin
                        report_mismatch("cycle_left", int'(m_cycle_left),
                                        int'(want.cycle_left));
                    end
                end
            end
        end
    end

    // The receiver stalls in about a fifth of the cycles unless the run is
    // in its quiet stretch.
    always @(negedge aclk) begin
        m_ready <= !aresetn ? 1'b0 : (quiet || $urandom_range(99) >= 21);
    end

    // Presents one command transaction and returns at the falling edge after
    // it was taken. Valid may drop for a short gap before the transaction but
    // never while one is waiting. Ignored commands are not counted.
    task automatic send_item(input logic [CMD_W-1:0] command,
                             input logic [VERTEX_W-1:0] src,
                             input logic [VERTEX_W-1:0] dest,
                             input logic typed = 1'b0,
                             input vtx_result_t want = '0);
        if (!quiet && $urandom_range(99) < 21) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid    = 1'b1;
        s_command  = command;
        s_src      = src;
        s_dest     = dest;
        sort_typed = typed;
        sort_want  = want;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (command != CMD_UNUSED &&
            !(command == CMD_ADD_EDGE && (src >= live_count() || dest >= live_count()))) begin
            items_sent++;
        end
        @(negedge aclk);
    endtask

    // The register may only change while the engine is idle: wait for every
    // owed vertex, let the engine settle, then write for one cycle.
    task automatic set_vertex_count(input logic [COUNT_W-1:0] value);
        s_valid = 1'b0;
        while (expected_order.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
    endtask

    function automatic stim_row_t item_row(input logic [CMD_W-1:0] command,
                                           input logic [VERTEX_W-1:0] src,
                                           input logic [VERTEX_W-1:0] dest);
        return '{kind: ROW_ITEM, count: '0, command: command, src: src, dest: dest,
                 typed: 1'b0, want: '0};
    endfunction

    function automatic stim_row_t count_row(input logic [COUNT_W-1:0] value);
        return '{kind: ROW_COUNT, count: value, command: CMD_SORT, src: '0, dest: '0,
                 typed: 1'b0, want: '0};
    endfunction

    function automatic stim_row_t sort_row(input logic [VERTEX_W-1:0] vertex,
                                           input logic valid_vertex,
                                           input logic cycle_left);
        return '{kind: ROW_ITEM, count: '0,
                 command: CMD_SORT, src: '0, dest: '0, typed: 1'b1,
                 want: '{vertex: vertex, valid_vertex: valid_vertex, last: 1'b1,
                         cycle_left: cycle_left}};
    endfunction

    initial begin
        int unsigned         phase;
        int unsigned         big_runs;
        int unsigned         pick;
        int unsigned         live;
        int unsigned         num_edges;
        int unsigned         a;
        int unsigned         b;
        int unsigned         tmp;
        logic                loops_ok;
        logic [COUNT_W-1:0]  value;
        logic [VERTEX_W-1:0] far_end;
        int                  perm [NUM_VERTICES];

        // Right after reset the count is zero, so nothing can be emitted
        // and nothing counts as left over.
        directed_rows.push_back(sort_row(6'd0, 1'b0, 1'b0));
        // Both endpoints lie beyond an empty graph, so this edge is dropped.
        directed_rows.push_back(item_row(CMD_ADD_EDGE, 6'd0, 6'd1));
        directed_rows.push_back(count_row(7'd1));
        // A lone vertex with no edges comes out by itself.
        directed_rows.push_back(sort_row(6'd0, 1'b1, 1'b0));
        // A self loop keeps its vertex from ever reaching in-degree zero.
        directed_rows.push_back(item_row(CMD_ADD_EDGE, 6'd0, 6'd0));
        directed_rows.push_back(sort_row(6'd0, 1'b0, 1'b1));
        directed_rows.push_back(item_row(CMD_UNUSED, 6'd63, 6'd63));
        // Full matrix: corner edges, a repeated edge, and a vertex stuck
        // behind the self loop.
        directed_rows.push_back(count_row(7'd64));
        directed_rows.push_back(item_row(CMD_ADD_EDGE, 6'd63, 6'd0));
        directed_rows.push_back(item_row(CMD_ADD_EDGE, 6'd62, 6'd63));
        directed_rows.push_back(item_row(CMD_ADD_EDGE, 6'd62, 6'd63));
        directed_rows.push_back(item_row(CMD_ADD_EDGE, 6'd0, 6'd5));
        directed_rows.push_back(item_row(CMD_ADD_EDGE, 6'd42, 6'd21));
        directed_rows.push_back(item_row(CMD_SORT, 6'd0, 6'd0));
        // A count past the matrix size acts as the full matrix.
        directed_rows.push_back(count_row(7'd127));
        directed_rows.push_back(item_row(CMD_SORT, 6'd63, 6'd63));
        // Lowering the count leaves stale edges in place but out of the sort.
        directed_rows.push_back(count_row(7'd3));
        directed_rows.push_back(item_row(CMD_SORT, 6'd0, 6'd0));
        directed_rows.push_back(item_row(CMD_CLEAR, 6'd63, 6'd63));
        directed_rows.push_back(item_row(CMD_SORT, 6'd0, 6'd0));
        // Two vertices on a cycle: nothing comes out.
        directed_rows.push_back(count_row(7'd2));
        directed_rows.push_back(item_row(CMD_ADD_EDGE, 6'd1, 6'd0));
        directed_rows.push_back(item_row(CMD_ADD_EDGE, 6'd0, 6'd1));
        directed_rows.push_back(sort_row(6'd0, 1'b0, 1'b1));
        // Edges with one endpoint out of range are dropped.
        directed_rows.push_back(item_row(CMD_ADD_EDGE, 6'd2, 6'd0));
        directed_rows.push_back(item_row(CMD_ADD_EDGE, 6'd0, 6'd63));
        directed_rows.push_back(item_row(CMD_CLEAR, 6'd0, 6'd0));
        directed_rows.push_back(item_row(CMD_ADD_EDGE, 6'd1, 6'd0));
        directed_rows.push_back(item_row(CMD_SORT, 6'd0, 6'd0));

        // Synchronous reset, released at a falling edge.
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_COUNT) begin
                set_vertex_count(directed_rows[k].count);
            end else begin
                send_item(directed_rows[k].command, directed_rows[k].src,
                          directed_rows[k].dest, directed_rows[k].typed,
                          directed_rows[k].want);
            end
        end

        // Random part. Each phase picks a vertex count, usually clears the
        // graph, loads a random DAG along a shuffled vertex order, and sorts.
        // Some phases also get back edges or self loops, so that vertices
        // are left over; out-of-range edges and unused commands add noise.
        items_sent = 0;
        phase      = 0;
        big_runs   = 0;
        while (items_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 4 && big_runs < 2) begin
                big_runs++;
                value = (pick < 2) ? 7'd64 : 7'($urandom_range(65, 127));
            end else if (pick < 12) begin
                value = 7'($urandom_range(0, 1));
            end else begin
                value = 7'($urandom_range(2, 14));
            end
            set_vertex_count(value);
            quiet    = (phase >= 10 && phase < 16);
            live     = live_count();
            loops_ok = ($urandom_range(99) < 30);

            if ($urandom_range(99) < 75) begin
                send_item(CMD_CLEAR, VERTEX_W'($urandom), VERTEX_W'($urandom));
            end

            for (int i = 0; i < NUM_VERTICES; i++) perm[i] = i;
            for (int i = int'(live) - 1; i > 0; i--) begin
                a       = $urandom_range(0, i);
                tmp     = perm[i];
                perm[i] = perm[a];
                perm[a] = tmp;
            end

            num_edges = (live < 2) ? $urandom_range(0, 2) : $urandom_range(1, 2 * live);
            for (int e = 0; e < num_edges; e++) begin
                pick = $urandom_range(99);
                if (live >= 2 && pick < 82) begin
                    // Forward along the shuffled order keeps the graph acyclic.
                    a = $urandom_range(0, live - 2);
                    b = $urandom_range(a + 1, live - 1);
                    send_item(CMD_ADD_EDGE, VERTEX_W'(perm[a]), VERTEX_W'(perm[b]));
                end else if (loops_ok && live >= 2 && pick < 88) begin
                    a = $urandom_range(0, live - 2);
                    b = $urandom_range(a + 1, live - 1);
                    send_item(CMD_ADD_EDGE, VERTEX_W'(perm[b]), VERTEX_W'(perm[a]));
                end else if (loops_ok && live >= 1 && pick < 91) begin
                    a = $urandom_range(0, live - 1);
                    send_item(CMD_ADD_EDGE, VERTEX_W'(a), VERTEX_W'(a));
                end else if (live < NUM_VERTICES && pick < 96) begin
                    far_end = VERTEX_W'($urandom_range(live, NUM_VERTICES - 1));
                    if ($urandom_range(1)) begin
                        send_item(CMD_ADD_EDGE, far_end, VERTEX_W'($urandom));
                    end else begin
                        send_item(CMD_ADD_EDGE, VERTEX_W'($urandom), far_end);
                    end
                end else begin
                    send_item(CMD_UNUSED, VERTEX_W'($urandom), VERTEX_W'($urandom));
                end
            end

            send_item(CMD_SORT, VERTEX_W'($urandom), VERTEX_W'($urandom));
            // A second sort must give the same order, since sorting leaves
            // the graph untouched.
            if ($urandom_range(99) < 15) begin
                send_item(CMD_SORT, VERTEX_W'($urandom), VERTEX_W'($urandom));
            end
            phase++;
        end
        quiet = 1'b0;

        s_valid = 1'b0;
        while (expected_order.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("topological_sort_engine test passed");
        end else begin
            $display("topological_sort_engine test failed");
        end
        $finish;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("topological_sort_engine test failed");
        $finish;
    end

endmodule

`default_nettype wire
